@@ rtl/core/jtagbb_pkg.sv @@
package jtagbb_pkg;

   // return queue geometry and timer width
   localparam int FIFO_DEPTH = 256;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
   localparam int TICK_WIDTH = 16;

   // register widths
   localparam int KA_W   = 16;
   localparam int PL_W   = 6;
   localparam int CSR_DW = 16;
   localparam int CMP_W  = (TICK_WIDTH > KA_W) ? TICK_WIDTH : KA_W;

   localparam logic [PL_W-1:0] MAX_PAYLOAD = PL_W'(62);

   // register indexes
   localparam logic CSR_KEEPALIVE = 1'b0;
   localparam logic CSR_PAYLOAD   = 1'b1;

   // request function codes
   localparam logic [1:0] FUNC_HOST = 2'd0;
   localparam logic [1:0] FUNC_POLL = 2'd1;
   localparam logic [1:0] FUNC_TICK = 2'd2;

   // packet constants
   localparam logic [7:0] HDR_BYTE0 = 8'h31;
   localparam logic [7:0] HDR_BYTE1 = 8'h60;
   localparam logic [7:0] READ_FILL = 8'hFF;
   localparam logic [7:0] TDO_TAG   = 8'h02;

   localparam logic KIND_PIN    = 1'b0;
   localparam logic KIND_PACKET = 1'b1;

   typedef enum logic [1:0] {
      OP_HOST,
      OP_POLL,
      OP_TICK,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] host_byte;
      logic       tdo_level;
      logic [7:0] tdo_shift_byte;
   } item_type;

   typedef struct packed {
      logic tck;
      logic tms;
      logic tdi;
      logic ncs;
      logic led;
   } pins_type;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] packet_byte;
      logic       last_of_packet;
      pins_type   pins;
      logic [7:0] shift_byte;
      logic       shift_start;
      logic       fifo_overflow;
   } rsp_word_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_HDR0,
      BK_HDR1,
      BK_DATA
   } back_state_type;

endpackage

@@ rtl/core/jtag_bitbang_byteshift_engine_top.sv @@
// jtag bit-bang / byte-shift engine
//
// request channel (req_*): one word per host command byte, return poll or timer
// tick, selected by req_func. words enter a two-word queue in the front end, so
// the host side keeps going while the result side is stalled.
// result channel (rsp_*): a command byte gives exactly one pin/shift update word
// (result_kind 0). a poll gives a packet: header 0x31, 0x60 and then up to
// payload_limit queued read-back bytes, last_of_packet on the final byte; with
// nothing queued it gives a header-only keepalive once the tick count has run
// out, else nothing. ticks and unused codes give no word.
// timing: a command byte goes from its queue slot to the result register; a
// packet's first header byte passes the first header state as well. while
// rsp_ready allows, the sequencer takes one request per cycle, so command bytes
// and ticks sustain one per cycle; a packet holds it in both header states and
// a data state per payload byte, one word per cycle out of the return ram.
// stall: rsp_valid holds its word until rsp_ready; the sequencer waits and the
// queue fills, then req_ready drops.
// reset: pins idle with chip select high, bit-bang mode, fifo and tick count
// cleared, keepalive_ticks 10, payload_limit 62. registers (csr_*) are written
// at once whenever csr_write_en is high, intended while the engine is idle.
module jtag_bitbang_byteshift_engine_top (
   input  logic                          clock,
   input  logic                          reset,
   // request words
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_func,
   input  logic [7:0]                    req_host_byte,
   input  logic                          req_tdo_level,
   input  logic [7:0]                    req_tdo_shift_byte,
   // result words
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_result_kind,
   output logic [7:0]                    rsp_packet_byte,
   output logic                          rsp_last_of_packet,
   output logic                          rsp_tck_level,
   output logic                          rsp_tms_level,
   output logic                          rsp_tdi_level,
   output logic                          rsp_chip_select_n,
   output logic                          rsp_led_level,
   output logic [7:0]                    rsp_shift_byte,
   output logic                          rsp_shift_start,
   output logic                          rsp_fifo_overflow,
   // register writes: index 0 keepalive_ticks, index 1 payload_limit
   input  logic                          csr_write_en,
   input  logic                          csr_index,
   input  logic [jtagbb_pkg::CSR_DW-1:0] csr_wdata
);

   jtagbb_pkg::item_type     q_item;
   jtagbb_pkg::rsp_word_type rsp_word;
   logic                     q_valid;
   logic                     q_pop;

   // front end: classify and queue request words
   jtagbb_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_host_byte      (req_host_byte),
      .req_tdo_level      (req_tdo_level),
      .req_tdo_shift_byte (req_tdo_shift_byte),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop)
   );

   // back end: pin state, return fifo, packet sequencer
   jtagbb_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_word     (rsp_word)
   );

   // unpack the result word onto its ports
   assign rsp_result_kind    = rsp_word.result_kind;
   assign rsp_packet_byte    = rsp_word.packet_byte;
   assign rsp_last_of_packet = rsp_word.last_of_packet;
   assign rsp_tck_level      = rsp_word.pins.tck;
   assign rsp_tms_level      = rsp_word.pins.tms;
   assign rsp_tdi_level      = rsp_word.pins.tdi;
   assign rsp_chip_select_n  = rsp_word.pins.ncs;
   assign rsp_led_level      = rsp_word.pins.led;
   assign rsp_shift_byte     = rsp_word.shift_byte;
   assign rsp_shift_start    = rsp_word.shift_start;
   assign rsp_fifo_overflow  = rsp_word.fifo_overflow;

endmodule

@@ rtl/core/jtagbb_ram.sv @@
module jtagbb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/jtagbb_front.sv @@
module jtagbb_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_func,
   input  logic [7:0]          req_host_byte,
   input  logic                req_tdo_level,
   input  logic [7:0]          req_tdo_shift_byte,
   output logic                q_valid,
   output jtagbb_pkg::item_type q_item,
   input  logic                q_pop
);

   jtagbb_pkg::item_type slot_ff [2];
   jtagbb_pkg::item_type slot_in [2];
   jtagbb_pkg::item_type new_item;
   logic [1:0]           cnt_ff;
   logic [1:0]           cnt_in;
   logic                 wr_idx;
   logic                 push;

   // classify the request
   always_comb begin
      new_item.host_byte      = req_host_byte;
      new_item.tdo_level      = req_tdo_level;
      new_item.tdo_shift_byte = req_tdo_shift_byte;
      unique case (req_func)
         jtagbb_pkg::FUNC_HOST: new_item.op = jtagbb_pkg::OP_HOST;
         jtagbb_pkg::FUNC_POLL: new_item.op = jtagbb_pkg::OP_POLL;
         jtagbb_pkg::FUNC_TICK: new_item.op = jtagbb_pkg::OP_TICK;
         default:               new_item.op = jtagbb_pkg::OP_NONE;
      endcase
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = slot_ff[0];
   assign wr_idx    = cnt_ff[0] && !q_pop;

   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      if (q_pop) begin
         slot_in[0] = slot_ff[1];
      end
      if (push) begin
         slot_in[wr_idx] = new_item;
      end
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ rtl/core/jtagbb_back.sv @@
module jtagbb_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  jtagbb_pkg::item_type          q_item,
   output logic                          q_pop,
   input  logic                          csr_write_en,
   input  logic                          csr_index,
   input  logic [jtagbb_pkg::CSR_DW-1:0] csr_wdata,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output jtagbb_pkg::rsp_word_type      rsp_word
);

   localparam int AW = jtagbb_pkg::FIFO_AW;
   localparam int CW = jtagbb_pkg::FIFO_CW;
   localparam int TW = jtagbb_pkg::TICK_WIDTH;
   localparam logic [CW-1:0] DEPTH_C = CW'(jtagbb_pkg::FIFO_DEPTH);
   localparam logic [AW-1:0] LAST_PTR = AW'(jtagbb_pkg::FIFO_DEPTH - 1);
   localparam logic [TW-1:0] TICK_MAX = {TW{1'b1}};

   jtagbb_pkg::back_state_type state_ff, state_in;
   jtagbb_pkg::pins_type       pins_ff, pins_in;
   jtagbb_pkg::rsp_word_type   rsp_ff, rsp_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       shift_mode_ff, shift_mode_in;
   logic [5:0]                 bytes_left_ff, bytes_left_in;
   logic                       read_back_ff, read_back_in;
   logic [AW-1:0]              wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]              rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [TW-1:0]              tick_ff, tick_in;
   logic [5:0]                 n_left_ff, n_left_in;
   logic                       keep_ff, keep_in;
   logic [jtagbb_pkg::KA_W-1:0] ka_ff;
   logic [jtagbb_pkg::PL_W-1:0] pl_ff;

   logic                       out_free;
   logic                       tick_hit;
   logic                       have_data;
   logic [jtagbb_pkg::CMP_W-1:0] thr_raw, thr_c;
   logic [jtagbb_pkg::PL_W-1:0]  lim;
   logic [5:0]                 n_take;
   logic                       ram_we;
   logic [7:0]                 ram_wdata;
   logic [7:0]                 ram_q;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign have_data = (count_ff != '0);
   assign q_pop     = (state_ff == jtagbb_pkg::BK_IDLE) && q_valid && out_free;

   // keepalive threshold and payload limit after clamping
   always_comb begin
      thr_raw  = (ka_ff == '0) ? jtagbb_pkg::CMP_W'(1) : jtagbb_pkg::CMP_W'(ka_ff);
      thr_c    = (thr_raw > jtagbb_pkg::CMP_W'(TICK_MAX)) ?
                 jtagbb_pkg::CMP_W'(TICK_MAX) : thr_raw;
      tick_hit = (jtagbb_pkg::CMP_W'(tick_ff) >= thr_c);
      if (pl_ff == '0) begin
         lim = jtagbb_pkg::PL_W'(1);
      end else if (pl_ff > jtagbb_pkg::MAX_PAYLOAD) begin
         lim = jtagbb_pkg::MAX_PAYLOAD;
      end else begin
         lim = pl_ff;
      end
      n_take = (count_ff < CW'(lim)) ? count_ff[5:0] : lim;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         jtagbb_pkg::BK_IDLE: begin
            if (q_pop && (q_item.op == jtagbb_pkg::OP_POLL) && (have_data || tick_hit)) begin
               state_in = jtagbb_pkg::BK_HDR0;
            end
         end
         jtagbb_pkg::BK_HDR0: begin
            if (out_free) begin
               state_in = jtagbb_pkg::BK_HDR1;
            end
         end
         jtagbb_pkg::BK_HDR1: begin
            if (out_free) begin
               state_in = keep_ff ? jtagbb_pkg::BK_IDLE : jtagbb_pkg::BK_DATA;
            end
         end
         jtagbb_pkg::BK_DATA: begin
            if (out_free && (n_left_ff == 6'd1)) begin
               state_in = jtagbb_pkg::BK_IDLE;
            end
         end
         default: state_in = jtagbb_pkg::BK_IDLE;
      endcase
   end

   // datapath and result word
   always_comb begin
      logic       push_req;
      logic [7:0] push_val;
      logic       drop;
      push_req      = 1'b0;
      push_val      = '0;
      drop          = 1'b0;
      pins_in       = pins_ff;
      shift_mode_in = shift_mode_ff;
      bytes_left_in = bytes_left_ff;
      read_back_in  = read_back_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      count_in      = count_ff;
      tick_in       = tick_ff;
      n_left_in     = n_left_ff;
      keep_in       = keep_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      ram_we        = 1'b0;
      ram_wdata     = '0;

      unique case (state_ff)
         jtagbb_pkg::BK_IDLE: begin
            if (q_pop) begin
               case (q_item.op)
                  jtagbb_pkg::OP_HOST: begin
                     rsp_in = '0;
                     if (!shift_mode_ff) begin
                        read_back_in = q_item.host_byte[6];
                        if (q_item.host_byte[7]) begin
                           pins_in.tck   = 1'b0;
                           bytes_left_in = q_item.host_byte[5:0];
                           shift_mode_in = (q_item.host_byte[5:0] != 6'd0);
                        end else begin
                           pins_in.tck = q_item.host_byte[0];
                           pins_in.tms = q_item.host_byte[1];
                           pins_in.ncs = q_item.host_byte[3];
                           pins_in.tdi = q_item.host_byte[4];
                           pins_in.led = q_item.host_byte[5];
                           push_req    = q_item.host_byte[6];
                           push_val    = jtagbb_pkg::TDO_TAG | {7'd0, q_item.tdo_level};
                        end
                     end else begin
                        rsp_in.shift_byte  = q_item.host_byte;
                        rsp_in.shift_start = 1'b1;
                        push_req           = read_back_ff;
                        push_val           = pins_ff.ncs ? q_item.tdo_shift_byte :
                                             jtagbb_pkg::READ_FILL;
                        bytes_left_in      = bytes_left_ff - 6'd1;
                        if (bytes_left_ff == 6'd1) begin
                           shift_mode_in = 1'b0;
                        end
                     end
                     // queue a read-back byte unless the fifo is full
                     if (push_req) begin
                        if (count_ff >= DEPTH_C) begin
                           drop = 1'b1;
                        end else begin
                           ram_we    = 1'b1;
                           ram_wdata = push_val;
                           wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + AW'(1);
                           count_in  = count_ff + CW'(1);
                        end
                     end
                     rsp_in.result_kind   = jtagbb_pkg::KIND_PIN;
                     rsp_in.pins          = pins_in;
                     rsp_in.fifo_overflow = drop;
                     rsp_valid_in         = 1'b1;
                  end
                  jtagbb_pkg::OP_POLL: begin
                     if (have_data || tick_hit) begin
                        tick_in   = '0;
                        n_left_in = n_take;
                        keep_in   = !have_data;
                     end
                  end
                  jtagbb_pkg::OP_TICK: begin
                     if (tick_ff != TICK_MAX) begin
                        tick_in = tick_ff + TW'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         jtagbb_pkg::BK_HDR0: begin
            if (out_free) begin
               rsp_in             = '0;
               rsp_in.result_kind = jtagbb_pkg::KIND_PACKET;
               rsp_in.packet_byte = jtagbb_pkg::HDR_BYTE0;
               rsp_in.pins        = pins_ff;
               rsp_valid_in       = 1'b1;
            end
         end
         jtagbb_pkg::BK_HDR1: begin
            if (out_free) begin
               rsp_in                = '0;
               rsp_in.result_kind    = jtagbb_pkg::KIND_PACKET;
               rsp_in.packet_byte    = jtagbb_pkg::HDR_BYTE1;
               rsp_in.last_of_packet = keep_ff;
               rsp_in.pins           = pins_ff;
               rsp_valid_in          = 1'b1;
            end
         end
         jtagbb_pkg::BK_DATA: begin
            if (out_free) begin
               rsp_in                = '0;
               rsp_in.result_kind    = jtagbb_pkg::KIND_PACKET;
               rsp_in.packet_byte    = ram_q;
               rsp_in.last_of_packet = (n_left_ff == 6'd1);
               rsp_in.pins           = pins_ff;
               rsp_valid_in          = 1'b1;
               rd_ptr_in             = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + AW'(1);
               count_in              = count_ff - CW'(1);
               n_left_in             = n_left_ff - 6'd1;
            end
         end
         default: begin
         end
      endcase
   end

   // read address runs one step ahead so the data is ready when the pointer lands
   jtagbb_ram #(
      .WIDTH (8),
      .DEPTH (jtagbb_pkg::FIFO_DEPTH)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (ram_wdata),
      .rd_addr (rd_ptr_in),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff      <= jtagbb_pkg::BK_IDLE;
         pins_ff       <= '{tck: 1'b0, tms: 1'b0, tdi: 1'b0, ncs: 1'b1, led: 1'b0};
         rsp_valid_ff  <= 1'b0;
         shift_mode_ff <= 1'b0;
         bytes_left_ff <= '0;
         read_back_ff  <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
         tick_ff       <= '0;
         n_left_ff     <= '0;
         keep_ff       <= 1'b0;
         ka_ff         <= jtagbb_pkg::KA_W'(10);
         pl_ff         <= jtagbb_pkg::MAX_PAYLOAD;
      end else begin
         state_ff      <= state_in;
         pins_ff       <= pins_in;
         rsp_valid_ff  <= rsp_valid_in;
         shift_mode_ff <= shift_mode_in;
         bytes_left_ff <= bytes_left_in;
         read_back_ff  <= read_back_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
         tick_ff       <= tick_in;
         n_left_ff     <= n_left_in;
         keep_ff       <= keep_in;
         if (csr_write_en && (csr_index == jtagbb_pkg::CSR_KEEPALIVE)) begin
            ka_ff <= csr_wdata[jtagbb_pkg::KA_W-1:0];
         end
         if (csr_write_en && (csr_index == jtagbb_pkg::CSR_PAYLOAD)) begin
            pl_ff <= csr_wdata[jtagbb_pkg::PL_W-1:0];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // fifo never holds more than its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("return fifo count beyond depth");

   // payload bytes are only walked while the fifo has them
   a_data_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == jtagbb_pkg::BK_DATA) |-> (count_ff != '0) && (n_left_ff != 6'd0))
      else $error("payload walk with empty fifo");

   // byte-shift mode always has bytes to go
   a_shift_len: assert property (@(posedge clock) disable iff (reset)
      shift_mode_ff |-> (bytes_left_ff != 6'd0))
      else $error("shift mode with zero length");

   // a taken first header byte is followed by the second
   a_hdr_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == jtagbb_pkg::BK_HDR0) && out_free |=> (state_ff == jtagbb_pkg::BK_HDR1))
      else $error("header sequence broken");

endmodule
